FILE: rtl/sp_interp_pkg.sv
// Package for the setpoint interpolator: default widths, command codes and the
// command/status structs that join the controller and the datapath.
// No dependencies.
package sp_interp_pkg;

  localparam int TIME_BITS_DEF  = 48;
  localparam int VALUE_BITS_DEF = 32;
  localparam int TIMEOUT_W      = 32;

  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 32'd1000000;

  localparam logic [1:0] CMD_ACCEPT = 2'd0;
  localparam logic [1:0] CMD_INTERP = 2'd1;
  localparam logic [1:0] CMD_RESET  = 2'd2;

  typedef struct packed {
    logic load;
    logic eval;
    logic prep;
    logic dsum;
    logic mul_step;
    logic div_step;
    logic hold;
    logic apply;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] code;
    logic       go_ok;
    logic       d_zero;
  } dp_status_t;

endpackage

FILE: rtl/sp_interp_ctrl.sv
// Controller of the setpoint interpolator: sequences one request through
// evaluation, serial multiply, serial divide and the result register.
// Depends on sp_interp_pkg.
module sp_interp_ctrl #(
  parameter int VALUE_BITS = sp_interp_pkg::VALUE_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output sp_interp_pkg::dp_cmd_t    cmd_o,
  input  sp_interp_pkg::dp_status_t status_i
);
  import sp_interp_pkg::*;

  localparam int QW   = VALUE_BITS + 1;
  localparam int CNTW = $clog2(QW);

  typedef enum logic [3:0] {
    S_IDLE,
    S_EVAL,
    S_PREP,
    S_DSUM,
    S_MUL,
    S_DIV,
    S_HOLD,
    S_APPLY,
    S_RESULT
  } state_e;

  state_e            state_q;
  logic [CNTW-1:0]   cnt_q;
  logic              out_valid_q;
  logic              last_step;
  logic              out_free;

  assign last_step   = (cnt_q == CNTW'(QW - 1));
  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o = '0;
    case (state_q)
      S_IDLE:   cmd_o.load     = in_valid_i;
      S_EVAL:   cmd_o.eval     = 1'b1;
      S_PREP:   cmd_o.prep     = 1'b1;
      S_DSUM:   cmd_o.dsum     = 1'b1;
      S_MUL:    cmd_o.mul_step = 1'b1;
      S_DIV:    cmd_o.div_step = 1'b1;
      S_HOLD:   cmd_o.hold     = 1'b1;
      S_APPLY:  cmd_o.apply    = 1'b1;
      S_RESULT: cmd_o.out_load = out_free;
      default:  cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (state_q == S_RESULT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) state_q <= S_EVAL;
        end
        S_EVAL: begin
          state_q <= (status_i.code == CMD_INTERP) ? S_PREP : S_RESULT;
        end
        S_PREP: state_q <= S_DSUM;
        S_DSUM: begin
          cnt_q <= '0;
          if (!status_i.go_ok || status_i.d_zero) begin
            state_q <= S_HOLD;
          end else begin
            state_q <= S_MUL;
          end
        end
        S_MUL: begin
          if (last_step) begin
            cnt_q   <= '0;
            state_q <= S_DIV;
          end else begin
            cnt_q <= cnt_q + CNTW'(1);
          end
        end
        S_DIV: begin
          if (last_step) begin
            state_q <= S_APPLY;
          end else begin
            cnt_q <= cnt_q + CNTW'(1);
          end
        end
        S_HOLD:  state_q <= S_RESULT;
        S_APPLY: state_q <= S_RESULT;
        S_RESULT: begin
          if (out_free) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/sp_interp_dp.sv
// Datapath of the setpoint interpolator: command and setpoint state, time
// checks, a shift-add multiplier and a restoring divider sharing one register.
// Depends on sp_interp_pkg.
module sp_interp_dp #(
  parameter int TIME_BITS  = sp_interp_pkg::TIME_BITS_DEF,
  parameter int VALUE_BITS = sp_interp_pkg::VALUE_BITS_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  sp_interp_pkg::dp_cmd_t                 cmd_i,
  output sp_interp_pkg::dp_status_t              status_o,
  input  logic                                   timeout_ticks_we_i,
  input  logic [sp_interp_pkg::TIMEOUT_W-1:0]    timeout_ticks_i,
  input  logic [1:0]                             cmd_code_i,
  input  logic [TIME_BITS-1:0]                   now_time_i,
  input  logic signed [VALUE_BITS-1:0]           command_value_i,
  output logic signed [VALUE_BITS-1:0]           interpolated_value_o,
  output logic                                   held_o,
  output logic signed [VALUE_BITS-1:0]           last_command_o,
  output logic [TIME_BITS-1:0]                   command_time_o
);
  import sp_interp_pkg::*;

  localparam int  QW   = VALUE_BITS + 1;
  localparam bit  SAT  = (TIME_BITS >= 64);
  localparam int  DW   = SAT ? TIME_BITS : TIME_BITS + 1;
  localparam int  AW   = DW + QW;
  localparam int  CMPW = (TIME_BITS > TIMEOUT_W) ? TIME_BITS : TIMEOUT_W;

  logic [TIMEOUT_W-1:0]  timeout_q;
  logic [1:0]            code_q;
  logic [TIME_BITS-1:0]  now_q;
  logic [VALUE_BITS-1:0] val_q;

  logic [VALUE_BITS-1:0] stored_q;
  logic [VALUE_BITS-1:0] interp_q;
  logic [TIME_BITS-1:0]  cmd_time_q;
  logic [TIME_BITS-1:0]  period_q;
  logic [TIME_BITS-1:0]  interp_time_q;

  logic [TIME_BITS-1:0]  since_q;
  logic [TIME_BITS-1:0]  t_q;
  logic                  ge_q;
  logic                  per_ok_q;
  logic [TIME_BITS-1:0]  rest_q;
  logic                  win_ok_q;
  logic [QW-1:0]         mag_q;
  logic                  neg_q;
  logic [DW-1:0]         d_q;
  logic [AW-1:0]         acc_q;
  logic                  held_q;

  logic [VALUE_BITS-1:0] out_value_q;
  logic                  out_held_q;
  logic [VALUE_BITS-1:0] out_last_q;
  logic [TIME_BITS-1:0]  out_time_q;

  logic [TIME_BITS:0]    since_full;
  logic [TIME_BITS:0]    t_full;
  logic [TIME_BITS:0]    rest_full;
  logic                  per_ok;
  logic [QW-1:0]         diff;
  logic [QW-1:0]         mag;
  logic [TIME_BITS:0]    dsum;
  logic [DW-1:0]         d_next;
  logic [DW:0]           mul_sum;
  logic [DW:0]           r_sh;
  logic [DW:0]           r_sub;
  logic                  r_ge;
  logic [QW-1:0]         iv_ext;
  logic [QW-1:0]         iv_new;

  assign since_full = {1'b0, now_q} - {1'b0, cmd_time_q};
  assign t_full     = {1'b0, now_q} - {1'b0, interp_time_q};
  assign per_ok     = CMPW'(period_q) <= CMPW'(timeout_q);
  assign rest_full  = {1'b0, period_q} - {1'b0, since_q};
  assign diff       = {stored_q[VALUE_BITS-1], stored_q} - {interp_q[VALUE_BITS-1], interp_q};
  assign mag        = diff[QW-1] ? (~diff + QW'(1)) : diff;
  assign dsum       = {1'b0, t_q} + {1'b0, rest_q};
  assign d_next     = (SAT && dsum[TIME_BITS]) ? {DW{1'b1}} : dsum[DW-1:0];

  assign mul_sum = {1'b0, acc_q[AW-1:QW]} + (acc_q[0] ? (DW+1)'(t_q) : '0);
  assign r_sh    = {acc_q[AW-1:QW], acc_q[QW-1]};
  assign r_sub   = r_sh - {1'b0, d_q};
  assign r_ge    = (r_sh >= {1'b0, d_q});

  assign iv_ext = {interp_q[VALUE_BITS-1], interp_q};
  assign iv_new = neg_q ? (iv_ext - acc_q[QW-1:0]) : (iv_ext + acc_q[QW-1:0]);

  assign status_o.code   = code_q;
  assign status_o.go_ok  = ge_q && per_ok_q && win_ok_q;
  assign status_o.d_zero = (t_q == '0) && (rest_q == '0);

  assign interpolated_value_o = out_value_q;
  assign held_o               = out_held_q;
  assign last_command_o       = out_last_q;
  assign command_time_o       = out_time_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q     <= TIMEOUT_RESET;
      stored_q      <= '0;
      interp_q      <= '0;
      cmd_time_q    <= '0;
      period_q      <= '0;
      interp_time_q <= '0;
    end else begin
      if (timeout_ticks_we_i) timeout_q <= timeout_ticks_i;
      if (cmd_i.eval) begin
        if (code_q == CMD_ACCEPT) begin
          period_q   <= since_full[TIME_BITS-1:0];
          cmd_time_q <= now_q;
          stored_q   <= val_q;
        end else if (code_q == CMD_RESET) begin
          stored_q      <= val_q;
          interp_q      <= val_q;
          period_q      <= '0;
          cmd_time_q    <= now_q;
          interp_time_q <= now_q;
        end
      end
      if (cmd_i.hold) begin
        interp_q      <= stored_q;
        interp_time_q <= now_q;
      end
      if (cmd_i.apply) begin
        interp_q      <= iv_new[VALUE_BITS-1:0];
        interp_time_q <= now_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      code_q <= cmd_code_i;
      now_q  <= now_time_i;
      val_q  <= command_value_i;
      held_q <= 1'b0;
    end
    if (cmd_i.eval) begin
      since_q  <= since_full[TIME_BITS-1:0];
      t_q      <= t_full[TIME_BITS-1:0];
      ge_q     <= !since_full[TIME_BITS] && !t_full[TIME_BITS];
      per_ok_q <= per_ok;
    end
    if (cmd_i.prep) begin
      rest_q   <= rest_full[TIME_BITS-1:0];
      win_ok_q <= !rest_full[TIME_BITS];
      mag_q    <= mag;
      neg_q    <= diff[QW-1];
    end
    if (cmd_i.dsum) begin
      d_q   <= d_next;
      acc_q <= {{DW{1'b0}}, mag_q};
    end
    if (cmd_i.mul_step) begin
      acc_q <= {mul_sum, acc_q[QW-1:1]};
    end
    if (cmd_i.div_step) begin
      acc_q <= {(r_ge ? r_sub[DW-1:0] : r_sh[DW-1:0]), acc_q[QW-2:0], r_ge};
    end
    if (cmd_i.hold) held_q <= 1'b1;
    if (cmd_i.out_load) begin
      out_value_q <= interp_q;
      out_held_q  <= held_q;
      out_last_q  <= stored_q;
      out_time_q  <= cmd_time_q;
    end
  end

endmodule

FILE: rtl/setpoint_interpolator_top.sv
// Setpoint interpolator: turns sparse position commands into a setpoint for
// every control tick.
// A request on the input channel carries a command code, a tick timestamp
// and a Q16.16 value; each request yields exactly one result on the output
// channel with the interpolated setpoint, the held flag, the stored command
// and its timestamp. The user must write the timeout register through its
// write enable only while the block is idle; the block does not enforce it.
// Accept, reset and the unused code go from evaluation straight to the
// result register. An interpolate request passes evaluation, preparation,
// the divisor sum, the bit-serial multiply and the restoring divide, which
// share one register and each take one bit per cycle, and the apply step; a
// held step goes through the hold step in place of multiply, divide and apply.
// One request is in work at a time; a new request is taken as soon as the
// previous result sits in the output register, even while it is stalled.
// When the receiver stalls, the result holds its value and the block stops
// before loading the next result. Reset clears the control state and the
// setpoint state to zero and sets the timeout to 1000000 ticks.
// Depends on sp_interp_pkg, sp_interp_ctrl and sp_interp_dp.
module setpoint_interpolator_top #(
  parameter int TIME_BITS  = sp_interp_pkg::TIME_BITS_DEF,
  parameter int VALUE_BITS = sp_interp_pkg::VALUE_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                timeout_ticks_we_i,
  input  logic [sp_interp_pkg::TIMEOUT_W-1:0] timeout_ticks_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [1:0]                          cmd_i,
  input  logic [TIME_BITS-1:0]                now_time_i,
  input  logic signed [VALUE_BITS-1:0]        command_value_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [VALUE_BITS-1:0]        interpolated_value_o,
  output logic                                held_o,
  output logic signed [VALUE_BITS-1:0]        last_command_o,
  output logic [TIME_BITS-1:0]                command_time_o
);
  import sp_interp_pkg::*;

  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;

  sp_interp_ctrl #(
    .VALUE_BITS(VALUE_BITS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .cmd_o      (dp_cmd),
    .status_i   (dp_status)
  );

  sp_interp_dp #(
    .TIME_BITS (TIME_BITS),
    .VALUE_BITS(VALUE_BITS)
  ) u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (dp_cmd),
    .status_o            (dp_status),
    .timeout_ticks_we_i  (timeout_ticks_we_i),
    .timeout_ticks_i     (timeout_ticks_i),
    .cmd_code_i          (cmd_i),
    .now_time_i          (now_time_i),
    .command_value_i     (command_value_i),
    .interpolated_value_o(interpolated_value_o),
    .held_o              (held_o),
    .last_command_o      (last_command_o),
    .command_time_o      (command_time_o)
  );

endmodule

FILE: rtl/sp_interp_chk.sv
// Port-level checker for the setpoint interpolator, bound to the top level.
// Depends on sp_interp_pkg and setpoint_interpolator_top.
module sp_interp_chk #(
  parameter int TIME_BITS  = sp_interp_pkg::TIME_BITS_DEF,
  parameter int VALUE_BITS = sp_interp_pkg::VALUE_BITS_DEF
) (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_stall_o,
  input logic [1:0]                          cmd_i,
  input logic signed [VALUE_BITS-1:0]        command_value_i,
  input logic                                out_valid_o,
  input logic                                out_stall_i,
  input logic signed [VALUE_BITS-1:0]        interpolated_value_o,
  input logic                                held_o,
  input logic signed [VALUE_BITS-1:0]        last_command_o,
  input logic [TIME_BITS-1:0]                command_time_o
);
  import sp_interp_pkg::*;

  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(interpolated_value_o) &&
      $stable(held_o) && $stable(last_command_o) && $stable(command_time_o))
    else $error("Stalled result changed.");

  a_one_at_a_time : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("Request taken while another is in work.");

  a_held_value : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && held_o |-> interpolated_value_o == last_command_o)
    else $error("Held result does not match the stored command.");

  a_reset_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !out_valid_o && cmd_i == CMD_RESET |->
      ##3 out_valid_o && !held_o && interpolated_value_o == $past(command_value_i, 3) &&
      last_command_o == $past(command_value_i, 3))
    else $error("Reset request result is wrong or late.");

endmodule

bind setpoint_interpolator_top sp_interp_chk #(
  .TIME_BITS (TIME_BITS),
  .VALUE_BITS(VALUE_BITS)
) u_sp_interp_chk (.*);

FILE: bench/tb.sv
// Self-checking testbench for setpoint_interpolator_top: directed and random
// requests under several timeout settings, checked against a cycle-free model.
// Depends on sp_interp_pkg and the RTL of the setpoint interpolator.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sp_interp_pkg::*;

  localparam int TW = TIME_BITS_DEF;
  localparam int VW = VALUE_BITS_DEF;
  localparam logic [1:0] CMD_SPARE = 2'd3;

  typedef struct packed {
    logic signed [VW-1:0] setpoint;
    logic                 held;
    logic signed [VW-1:0] last_cmd;
    logic [TW-1:0]        cmd_stamp;
  } setpoint_t;

  class setpoint_board;
    logic [TIMEOUT_W-1:0] timeout;
    logic signed [63:0]   stored;
    logic signed [63:0]   interp;
    logic [63:0]          cmd_time;
    logic [63:0]          cmd_period;
    logic [63:0]          interp_time;
    setpoint_t            setpoint_q[$];
    int                   n_requests;
    int                   n_checked;
    int                   n_moved;
    int                   n_held;
    int                   n_errors;

    function new();
      clear();
    endfunction

    function void clear();
      timeout     = TIMEOUT_RESET;
      stored      = '0;
      interp      = '0;
      cmd_time    = '0;
      cmd_period  = '0;
      interp_time = '0;
    endfunction

    function logic step_toward(logic [63:0] now);
      logic [63:0]        since;
      logic [63:0]        t;
      logic [63:0]        rest;
      logic [63:0]        d;
      logic [63:0]        mag;
      logic [127:0]       prod;
      logic [127:0]       q;
      logic signed [63:0] diff;
      logic               hold;
      hold = 1'b1;
      if (now >= cmd_time && now >= interp_time) begin
        since = now - cmd_time;
        if (since <= cmd_period && cmd_period <= {32'd0, timeout}) begin
          t    = now - interp_time;
          rest = cmd_period - since;
          d    = t + rest;
          if (d < t) begin
            d = '1;
          end
          if (d != 0) begin
            diff = stored - interp;
            mag  = (diff < 0) ? -diff : diff;
            prod = {64'd0, mag} * {64'd0, t};
            q    = prod / {64'd0, d};
            if (diff < 0) begin
              interp = interp - q[63:0];
            end else begin
              interp = interp + q[63:0];
            end
            hold = 1'b0;
          end
        end
      end
      if (hold) begin
        interp = stored;
      end
      interp_time = now;
      return hold;
    endfunction

    function void note_request(logic [1:0] code, logic [TW-1:0] now_t,
                               logic signed [VW-1:0] value);
      logic [63:0]   now;
      logic [TW-1:0] gap;
      logic          held;
      setpoint_t     exp;
      now  = {{(64-TW){1'b0}}, now_t};
      held = 1'b0;
      n_requests++;
      case (code)
        CMD_ACCEPT: begin
          gap        = now_t - cmd_time[TW-1:0];
          cmd_period = {{(64-TW){1'b0}}, gap};
          cmd_time   = now;
          stored     = value;
        end
        CMD_INTERP: begin
          held = step_toward(now);
          if (held) begin
            n_held++;
          end else begin
            n_moved++;
          end
        end
        CMD_RESET: begin
          stored      = value;
          interp      = value;
          cmd_period  = '0;
          cmd_time    = now;
          interp_time = now;
        end
        default: begin
        end
      endcase
      exp.setpoint  = interp[VW-1:0];
      exp.held      = held;
      exp.last_cmd  = stored[VW-1:0];
      exp.cmd_stamp = cmd_time[TW-1:0];
      setpoint_q.push_back(exp);
    endfunction

    function void check_setpoint(setpoint_t got);
      setpoint_t exp;
      if (setpoint_q.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) begin
          $display("Unexpected result: setpoint %0d held %0b last %0d time %0d",
                   got.setpoint, got.held, got.last_cmd, got.cmd_stamp);
        end
        return;
      end
      exp = setpoint_q.pop_front();
      n_checked++;
      if (got.setpoint !== exp.setpoint || got.held !== exp.held ||
          got.last_cmd !== exp.last_cmd || got.cmd_stamp !== exp.cmd_stamp) begin
        n_errors++;
        if (n_errors <= 10) begin
          $display("Result %0d: expected setpoint %0d held %0b last %0d time %0d",
                   n_checked, exp.setpoint, exp.held, exp.last_cmd, exp.cmd_stamp);
          $display("Result %0d: got      setpoint %0d held %0b last %0d time %0d",
                   n_checked, got.setpoint, got.held, got.last_cmd, got.cmd_stamp);
        end
      end
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  timeout_ticks_we_i = 1'b0;
  logic [TIMEOUT_W-1:0]  timeout_ticks_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  logic [1:0]            cmd_i = CMD_ACCEPT;
  logic [TW-1:0]         now_time_i = '0;
  logic signed [VW-1:0]  command_value_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic signed [VW-1:0]  interpolated_value_o;
  logic                  held_o;
  logic signed [VW-1:0]  last_command_o;
  logic [TW-1:0]         command_time_o;

  setpoint_board board = new();
  setpoint_t     seen;
  bit            idle_on = 1'b1;
  int            sent;
  int            n_settings = 1;
  logic [TW-1:0] tick_now;
  logic [63:0]   last_offs;

  setpoint_interpolator_top uut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .timeout_ticks_we_i  (timeout_ticks_we_i),
    .timeout_ticks_i     (timeout_ticks_i),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .cmd_i               (cmd_i),
    .now_time_i          (now_time_i),
    .command_value_i     (command_value_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .interpolated_value_o(interpolated_value_o),
    .held_o              (held_o),
    .last_command_o      (last_command_o),
    .command_time_o      (command_time_o)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    out_stall_i <= idle_on && ($urandom_range(99) < 20);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        board.note_request(cmd_i, now_time_i, command_value_i);
      end
      if (out_valid_o && !out_stall_i) begin
        seen.setpoint  = interpolated_value_o;
        seen.held      = held_o;
        seen.last_cmd  = last_command_o;
        seen.cmd_stamp = command_time_o;
        board.check_setpoint(seen);
      end
    end
  end

  task automatic send_request(logic [1:0] code, logic [TW-1:0] t, logic signed [VW-1:0] v);
    while (idle_on && $urandom_range(99) < 20) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    cmd_i           <= code;
    now_time_i      <= t;
    command_value_i <= v;
    do begin
      @(posedge clk_i);
    end while (in_stall_o);
    if (code != CMD_SPARE) begin
      sent++;
    end
  endtask

  task automatic write_timeout(logic [TIMEOUT_W-1:0] v);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (board.setpoint_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (80) @(posedge clk_i);
    timeout_ticks_we_i <= 1'b1;
    timeout_ticks_i    <= v;
    board.timeout = v;
    @(posedge clk_i);
    timeout_ticks_we_i <= 1'b0;
    n_settings++;
  endtask

  function automatic logic signed [VW-1:0] pick_value();
    int r;
    r = $urandom_range(99);
    if (r < 4) begin
      return {1'b0, {(VW-1){1'b1}}};
    end else if (r < 8) begin
      return {1'b1, {(VW-1){1'b0}}};
    end else if (r < 10) begin
      return '0;
    end else if (r < 40) begin
      return $signed($urandom_range(2000)) - 1000;
    end
    return $urandom;
  endfunction

  function automatic logic [63:0] pick_period();
    int          r;
    logic [63:0] base;
    r = $urandom_range(99);
    if (r < 5) begin
      return '0;
    end else if (r < 35) begin
      return 64'($urandom_range(20, 1));
    end else if (r < 65) begin
      return 64'($urandom_range(5000, 1));
    end else if (r < 80) begin
      base = {32'd0, board.timeout} + 64'($urandom_range(4));
      return (base >= 2) ? base - 2 : base;
    end else if (r < 95) begin
      return 64'($urandom);
    end
    return {16'd0, 16'($urandom_range(65535)), 32'($urandom)};
  endfunction

  task automatic run_sequence();
    logic [63:0]   period;
    logic [63:0]   offs;
    logic [63:0]   rnd;
    logic [TW-1:0] accept_t;
    int            n_ticks;
    int            r;
    if ($urandom_range(99) < 40) begin
      case ($urandom_range(3))
        0: tick_now = TW'({$urandom, $urandom});
        1: tick_now = '1 - TW'($urandom_range(100000));
        default: tick_now = tick_now + TW'($urandom_range(1000));
      endcase
      send_request(CMD_RESET, tick_now, pick_value());
      last_offs = '0;
    end
    repeat ($urandom_range(4, 1)) begin
      period = pick_period();
      if (period < last_offs) begin
        period = last_offs;
      end
      tick_now = tick_now + period[TW-1:0];
      accept_t = tick_now;
      send_request(CMD_ACCEPT, accept_t, pick_value());
      n_ticks = $urandom_range(6, 1);
      offs = '0;
      repeat (n_ticks) begin
        r = $urandom_range(99);
        rnd = {$urandom, $urandom};
        if (r < 8) begin
          offs = period;
        end else if (r < 14) begin
          offs = period + 64'($urandom_range(3, 1));
        end else if (r >= 20) begin
          offs = offs + rnd % (period / 64'(n_ticks) + 64'd1);
        end
        send_request(CMD_INTERP, accept_t + offs[TW-1:0], pick_value());
      end
      last_offs = offs;
    end
  endtask

  task automatic inject_noise();
    int r;
    r = $urandom_range(99);
    if (r < 50) begin
      tick_now = tick_now + TW'($urandom_range(50));
    end else if (r < 75) begin
      tick_now = tick_now - TW'($urandom_range(50, 1));
    end else begin
      tick_now = TW'({$urandom, $urandom});
    end
    last_offs = '0;
    send_request(2'($urandom_range(3)), tick_now, pick_value());
  endtask

  task automatic run_phase(int target);
    while (sent < target) begin
      if ($urandom_range(99) < 75) begin
        run_sequence();
      end else begin
        inject_noise();
      end
    end
  endtask

  task automatic run_directed();
    send_request(CMD_INTERP, 48'd0, 32'sd0);
    send_request(CMD_SPARE, 48'd5, 32'h1234_5678);
    send_request(CMD_RESET, 48'd100, 32'h7FFF_FFFF);
    send_request(CMD_ACCEPT, 48'd200, 32'h8000_0000);
    send_request(CMD_INTERP, 48'd250, 32'sd0);
    send_request(CMD_INTERP, 48'd300, 32'sd0);
    send_request(CMD_INTERP, 48'd301, 32'sd0);
    send_request(CMD_RESET, 48'd1000, 32'sd0);
    send_request(CMD_ACCEPT, 48'd1003, 32'sd7);
    send_request(CMD_ACCEPT, 48'd1006, 32'sd7);
    send_request(CMD_INTERP, 48'd1007, 32'h5A5A_A5A5);
    send_request(CMD_INTERP, 48'd1005, 32'sd0);
    send_request(CMD_ACCEPT, 48'd1000, -32'sd5);
    send_request(CMD_INTERP, 48'd1001, 32'sd0);
    send_request(CMD_RESET, 48'd2000, 32'sd0);
    send_request(CMD_ACCEPT, 48'd2003, -32'sd7);
    send_request(CMD_ACCEPT, 48'd2006, -32'sd7);
    send_request(CMD_INTERP, 48'd2007, 32'sd0);
    send_request(CMD_RESET, 48'd10000, 32'sd1);
    send_request(CMD_ACCEPT, 48'd2010000, 32'sd2);
    send_request(CMD_INTERP, 48'd2010001, 32'sd0);
    send_request(CMD_RESET, 48'hFFFF_FFFF_FFFF, -32'sd1);
    send_request(CMD_INTERP, 48'hFFFF_FFFF_FFFF, 32'sd0);
    tick_now  = 48'd5000;
    last_offs = '0;
  endtask

  initial begin
    logic [TIMEOUT_W-1:0] settings[6];
    settings[0] = '0;
    settings[1] = '1;
    settings[2] = $urandom_range(5000, 1);
    settings[3] = TIMEOUT_RESET;
    settings[4] = $urandom;
    settings[5] = $urandom_range(200, 1);
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_directed();
    foreach (settings[i]) begin
      write_timeout(settings[i]);
      idle_on = (i != 2);
      run_phase(sent + 240);
    end
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (board.setpoint_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (100) @(posedge clk_i);
    $display("Checked %0d results for %0d requests under %0d timeout settings.",
             board.n_checked, board.n_requests, n_settings);
    $display("Interpolate requests: %0d moved toward the command, %0d held it.",
             board.n_moved, board.n_held);
    if (board.n_errors == 0 && board.setpoint_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches, %0d results missing.", board.n_errors,
               board.setpoint_q.size());
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Watchdog expired with %0d results outstanding.", board.setpoint_q.size());
    $display("TB_ERROR");
    $finish;
  end

endmodule

FILE: setpoint_interpolator_top.f
rtl/sp_interp_pkg.sv
rtl/sp_interp_ctrl.sv
rtl/sp_interp_dp.sv
rtl/setpoint_interpolator_top.sv
rtl/sp_interp_chk.sv
bench/tb.sv
